@@ hw/rtl/scbb_pkg.sv @@
// ----------------------------------------------------------------------------
// scbb_pkg
// Shared types, widths and constants for the swept-circle bounding box.
// ----------------------------------------------------------------------------
package scbb_pkg;

  localparam int IN_W     = 24;   // centre and motion coordinates
  localparam int RAD_W    = 16;   // circle radius
  localparam int OUT_W    = 19;   // integer box bounds
  localparam int P_W      = 25;   // offset from the pivot
  localparam int Q_W      = 26;   // rotated offset and orbit radius, signed
  localparam int SQ_W     = 50;   // squared orbit radius (even for the root)
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int PROD_W   = 42;   // offset times rotation coefficient
  localparam int SUM_W    = 28;   // bound before truncation
  localparam int ROT_BITS = 16;

  localparam logic signed [16:0] COS60 = 17'sd32768;
  localparam logic signed [16:0] SIN60 = 17'sd56756;

  typedef enum logic [1:0] {
    MODE_STILL = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_CCW   = 2'd2,
    MODE_CW    = 2'd3
  } mode_t;

  // Everything an item carries alongside the square root.
  typedef struct packed {
    mode_t                   mode;
    logic signed [IN_W-1:0]  cx;
    logic signed [IN_W-1:0]  cy;
    logic [RAD_W-1:0]        r;
    logic signed [IN_W-1:0]  mx;
    logic signed [IN_W-1:0]  my;
    logic signed [P_W-1:0]   px;
    logic signed [P_W-1:0]   py;
    logic signed [Q_W-1:0]   qx;
    logic signed [Q_W-1:0]   qy;
  } side_t;

endpackage

@@ hw/rtl/swept_circle_bounding_box.sv @@
// Pipeline: 3 front stages, 25 root stages and 2 box stages lie between the start transfer and the
//   done strobe; the orbit square root, one bit per stage, sets that depth.
// Throughput: one item per cycle; busy is held low and a new start is taken every cycle.
// Results leave on a single-cycle done strobe and are never held back.
// Reset: synchronous rst clears the valid bits of every stage; data registers keep no reset.
// ----------------------------------------------------------------------------
// swept_circle_bounding_box
// Integer bounding box of a circle swept by a stationary, translating or
// 60 degree rotating motion.
// ----------------------------------------------------------------------------
module swept_circle_bounding_box import scbb_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode,
  input  logic signed [IN_W-1:0]  center_x,
  input  logic signed [IN_W-1:0]  center_y,
  input  logic [RAD_W-1:0]        circle_radius,
  input  logic signed [IN_W-1:0]  motion_x,
  input  logic signed [IN_W-1:0]  motion_y,
  output logic                    done,
  output logic signed [OUT_W-1:0] box_low_x,
  output logic signed [OUT_W-1:0] box_high_x,
  output logic signed [OUT_W-1:0] box_low_y,
  output logic signed [OUT_W-1:0] box_high_y
);

  // Front end: offset from the pivot, squared length and the rotated offset.
  logic              front_valid;
  side_t             front_side;
  logic [SQ_W-1:0]   front_sq;

  // Root pipeline: orbit radius, with the rest of the item riding alongside.
  logic              root_valid;
  side_t             root_side;
  logic [ROOT_W-1:0] root_val;

  // Every stage advances each cycle, so the block never refuses a transfer.
  assign busy = 1'b0;

  scbb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_mode   (mode_t'(mode)),
    .in_cx     (center_x),
    .in_cy     (center_y),
    .in_r      (circle_radius),
    .in_mx     (motion_x),
    .in_my     (motion_y),
    .out_valid (front_valid),
    .out_side  (front_side),
    .out_sq    (front_sq)
  );

  // The root is computed for every item; only rotations use it.
  scbb_root u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_side   (front_side),
    .in_sq     (front_sq),
    .out_valid (root_valid),
    .out_side  (root_side),
    .out_root  (root_val)
  );

  // Pick the box sides, add pivot and radius, truncate and apply margins.
  scbb_box #(
    .FRAC_BITS (FRAC_BITS)
  ) u_box (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .in_side   (root_side),
    .in_root   (root_val),
    .out_valid (done),
    .low_x     (box_low_x),
    .high_x    (box_high_x),
    .low_y     (box_low_y),
    .high_y    (box_high_y)
  );

endmodule

@@ hw/rtl/scbb_front.sv @@
// ----------------------------------------------------------------------------
// scbb_front
// Offset from the pivot, squares and rotation products, rotated offset.
// ----------------------------------------------------------------------------
module scbb_front import scbb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  mode_t                  in_mode,
  input  logic signed [IN_W-1:0] in_cx,
  input  logic signed [IN_W-1:0] in_cy,
  input  logic [RAD_W-1:0]       in_r,
  input  logic signed [IN_W-1:0] in_mx,
  input  logic signed [IN_W-1:0] in_my,
  output logic                   out_valid,
  output side_t                  out_side,
  output logic [SQ_W-1:0]        out_sq
);

  function automatic logic signed [Q_W-1:0] rot_round(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] t;
    t = v + (PROD_W+1)'(1 << (ROT_BITS - 1));
    return t[ROT_BITS+Q_W-1:ROT_BITS];
  endfunction

  // stage 0
  logic                   v0;
  mode_t                  mode0;
  logic signed [IN_W-1:0] cx0, cy0, mx0, my0;
  logic [RAD_W-1:0]       r0;
  logic signed [P_W-1:0]  px0, py0;

  // stage 1
  logic                    v1;
  mode_t                   mode1;
  logic signed [IN_W-1:0]  cx1, cy1, mx1, my1;
  logic [RAD_W-1:0]        r1;
  logic signed [P_W-1:0]   px1, py1;
  logic signed [SQ_W-1:0]  pxx1, pyy1;
  logic signed [PROD_W-1:0] pxc1, pxs1, pyc1, pys1;

  logic signed [PROD_W:0] sum_qx, sum_qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mode0 <= in_mode;
    cx0   <= in_cx;
    cy0   <= in_cy;
    r0    <= in_r;
    mx0   <= in_mx;
    my0   <= in_my;
    px0   <= {in_cx[IN_W-1], in_cx} - {in_mx[IN_W-1], in_mx};
    py0   <= {in_cy[IN_W-1], in_cy} - {in_my[IN_W-1], in_my};
  end

  always_ff @(posedge clk) begin
    mode1 <= mode0;
    cx1   <= cx0;
    cy1   <= cy0;
    r1    <= r0;
    mx1   <= mx0;
    my1   <= my0;
    px1   <= px0;
    py1   <= py0;
    pxx1  <= px0 * px0;
    pyy1  <= py0 * py0;
    pxc1  <= px0 * COS60;
    pxs1  <= px0 * SIN60;
    pyc1  <= py0 * COS60;
    pys1  <= py0 * SIN60;
  end

  // The clockwise arc is taken from the rotated offset back to the start.
  always_comb begin
    if (mode1 == MODE_CW) begin
      sum_qx = {pxc1[PROD_W-1], pxc1} + {pys1[PROD_W-1], pys1};
      sum_qy = {pyc1[PROD_W-1], pyc1} - {pxs1[PROD_W-1], pxs1};
    end else begin
      sum_qx = {pxc1[PROD_W-1], pxc1} - {pys1[PROD_W-1], pys1};
      sum_qy = {pxs1[PROD_W-1], pxs1} + {pyc1[PROD_W-1], pyc1};
    end
  end

  always_ff @(posedge clk) begin
    out_side.mode <= mode1;
    out_side.cx   <= cx1;
    out_side.cy   <= cy1;
    out_side.r    <= r1;
    out_side.mx   <= mx1;
    out_side.my   <= my1;
    out_side.px   <= px1;
    out_side.py   <= py1;
    out_side.qx   <= rot_round(sum_qx);
    out_side.qy   <= rot_round(sum_qy);
    out_sq        <= $unsigned(pxx1) + $unsigned(pyy1);
  end

endmodule

@@ hw/rtl/scbb_root.sv @@
// ----------------------------------------------------------------------------
// scbb_root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module scbb_root import scbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [SQ_W-1:0]   in_sq,
  output logic              out_valid,
  output side_t             out_side,
  output logic [ROOT_W-1:0] out_root
);

  logic              vld_q  [0:ROOT_W-1];
  side_t             side_q [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_q  [0:ROOT_W-2];
  logic [SQ_W-1:0]   n_q    [0:ROOT_W-2];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic              vld_i;
    side_t             side_i;
    logic [ROOT_W-1:0] root_i;
    logic [REM_W-1:0]  rem_i;
    logic [SQ_W-1:0]   n_i;
    logic [REM_W+1:0]  r2;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (g == 0) begin : g_head
      assign vld_i  = in_valid;
      assign side_i = in_side;
      assign root_i = '0;
      assign rem_i  = '0;
      assign n_i    = in_sq;
    end else begin : g_body
      assign vld_i  = vld_q[g-1];
      assign side_i = side_q[g-1];
      assign root_i = root_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign n_i    = n_q[g-1];
    end

    // Bring down the next two bits and try to subtract 4*root + 1.
    assign r2    = {rem_i, n_i[SQ_W-1:SQ_W-2]};
    assign trial = {root_i, 2'b01};
    assign take  = (r2 >= {2'b00, trial});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      side_q[g] <= side_i;
      root_q[g] <= {root_i[ROOT_W-2:0], take};
    end

    if (g < ROOT_W - 1) begin : g_carry
      logic [REM_W+1:0] diff;
      assign diff = r2 - {2'b00, trial};
      always_ff @(posedge clk) begin
        rem_q[g] <= take ? diff[REM_W-1:0] : r2[REM_W-1:0];
        n_q[g]   <= {n_i[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];
  assign out_root  = root_q[ROOT_W-1];

endmodule

@@ hw/rtl/scbb_box.sv @@
// ----------------------------------------------------------------------------
// scbb_box
// Side selection, radius and pivot offsets, truncation and margins.
// ----------------------------------------------------------------------------
module scbb_box import scbb_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic [ROOT_W-1:0]       in_root,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] low_x,
  output logic signed [OUT_W-1:0] high_x,
  output logic signed [OUT_W-1:0] low_y,
  output logic signed [OUT_W-1:0] high_y
);

  localparam logic [SUM_W-1:0] BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  function automatic logic signed [SUM_W-1:0] ext_in(input logic signed [IN_W-1:0] v);
    return {{(SUM_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_q(input logic signed [Q_W-1:0] v);
    return {{(SUM_W-Q_W){v[Q_W-1]}}, v};
  endfunction

  // Drop the fraction toward zero.
  function automatic logic signed [SUM_W-1:0] trunc_z(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + (v[SUM_W-1] ? BIAS : '0);
    return t >>> FRAC_BITS;
  endfunction

  logic signed [Q_W-1:0]   rad, px_e, py_e, lx, ux, ly, uy;
  logic signed [Q_W-1:0]   min_x, max_x, min_y, max_y;
  logic                    ssx, ssy, esx, esy;
  logic signed [SUM_W-1:0] rr, cx_e, cy_e, mx_e, my_e;
  logic signed [SUM_W-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;

  logic                    va;
  mode_t                   mode_a;
  logic signed [SUM_W-1:0] lo_x, hi_x, lo_y, hi_y;

  logic signed [SUM_W-1:0] k_lo;
  logic signed [SUM_W-1:0] t_lo_x, t_hi_x, t_lo_y, t_hi_y;

  always_comb begin
    rad   = {1'b0, in_root};
    px_e  = {in_side.px[P_W-1], in_side.px};
    py_e  = {in_side.py[P_W-1], in_side.py};
    min_x = (px_e < in_side.qx) ? px_e : in_side.qx;
    max_x = (px_e > in_side.qx) ? px_e : in_side.qx;
    min_y = (py_e < in_side.qy) ? py_e : in_side.qy;
    max_y = (py_e > in_side.qy) ? py_e : in_side.qy;

    if (in_side.mode == MODE_CW) begin
      ssx = in_side.qx > 0;
      ssy = in_side.qy > 0;
      esx = px_e > 0;
      esy = py_e > 0;
    end else begin
      ssx = px_e > 0;
      ssy = py_e > 0;
      esx = in_side.qx > 0;
      esy = in_side.qy > 0;
    end

    // Widen a side out to the orbit where the arc crosses an axis.
    lx = min_x;
    ux = max_x;
    ly = min_y;
    uy = max_y;
    if (ssy != esy) begin
      if (ssy) lx = -rad;
      else     ux = rad;
    end
    if (ssx != esx) begin
      if (ssx) uy = rad;
      else     ly = -rad;
    end

    rr   = {{(SUM_W-RAD_W){1'b0}}, in_side.r};
    cx_e = ext_in(in_side.cx);
    cy_e = ext_in(in_side.cy);
    mx_e = ext_in(in_side.mx);
    my_e = ext_in(in_side.my);

    case (in_side.mode)
      MODE_STILL: begin
        lo_x_next = cx_e - rr;
        hi_x_next = cx_e + rr;
        lo_y_next = cy_e - rr;
        hi_y_next = cy_e + rr;
      end
      MODE_SHIFT: begin
        lo_x_next = cx_e - rr + ((in_side.mx > 0) ? '0 : mx_e);
        hi_x_next = cx_e + rr + ((in_side.mx > 0) ? mx_e : '0);
        lo_y_next = cy_e - rr + ((in_side.my > 0) ? '0 : my_e);
        hi_y_next = cy_e + rr + ((in_side.my > 0) ? my_e : '0);
      end
      default: begin
        lo_x_next = ext_q(lx) + mx_e - rr;
        hi_x_next = ext_q(ux) + mx_e + rr;
        lo_y_next = ext_q(ly) + my_e - rr;
        hi_y_next = ext_q(uy) + my_e + rr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    mode_a <= in_side.mode;
    lo_x   <= lo_x_next;
    hi_x   <= hi_x_next;
    lo_y   <= lo_y_next;
    hi_y   <= hi_y_next;
  end

  // Translation keeps its low sides flush; every other case adds a low margin; high sides always get one.
  always_comb begin
    k_lo   = (mode_a == MODE_SHIFT) ? '0 : '1;
    t_lo_x = trunc_z(lo_x) + k_lo;
    t_hi_x = trunc_z(hi_x) + SUM_W'(1);
    t_lo_y = trunc_z(lo_y) + k_lo;
    t_hi_y = trunc_z(hi_y) + SUM_W'(1);
  end

  always_ff @(posedge clk) begin
    low_x  <= t_lo_x[OUT_W-1:0];
    high_x <= t_hi_x[OUT_W-1:0];
    low_y  <= t_lo_y[OUT_W-1:0];
    high_y <= t_hi_y[OUT_W-1:0];
  end

endmodule
